>>> hdl/vtlc_pkg.sv
// vtlc_pkg: shared types, codes and small tables for the frame transform block
// no dependencies
`default_nettype none

package vtlc_pkg;

    // function codes of a request
    localparam logic [1:0] FN_LOAD  = 2'd0;
    localparam logic [1:0] FN_XFORM = 2'd1;
    localparam logic [1:0] FN_ACCEL = 2'd2;
    localparam logic [1:0] FN_NOP   = 2'd3;

    // frame codes per axis
    localparam logic [1:0] FR_NONE   = 2'd0;
    localparam logic [1:0] FR_EYE    = 2'd1;
    localparam logic [1:0] FR_BODY   = 2'd2;
    localparam logic [1:0] FR_PARENT = 2'd3;

    // matrix store geometry
    localparam int unsigned STORE_DEPTH = 27;
    localparam int unsigned ADDR_W      = 5;
    localparam logic [1:0]  SEL_LIMIT   = 2'd3;
    localparam logic [3:0]  IDX_LIMIT   = 4'd9;

    // iterative unit modes
    localparam logic SD_SQRT = 1'b0;
    localparam logic SD_DIV  = 1'b1;

    // control from the sequencer to the sqrt / divide unit
    typedef struct packed {
        logic start;
        logic mode;
    } sd_ctrl_t;

    // write port of the matrix store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
    } mem_wr_t;

    // first word of a frame in the store (frame code 1..3)
    function automatic logic [ADDR_W-1:0] frame_base(input logic [1:0] code);
        logic [ADDR_W-1:0] b;
        case (code)
            FR_BODY:   b = 5'd9;
            FR_PARENT: b = 5'd18;
            default:   b = 5'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> hdl/vtlc_store.sv
// vtlc_store: 27-word matrix store with per-word valid bits, registered read
// depends on vtlc_pkg
`default_nettype none

module vtlc_store
    import vtlc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mem_wr_t           wr,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]            rd_data
);

    logic [31:0]            mem [0:STORE_DEPTH-1];
    logic [STORE_DEPTH-1:0] vld_reg;
    logic [31:0]            rd_data_reg;

    // storage words, no reset
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // valid bits, an unwritten word reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.en)
        begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= vld_reg[rd_addr] ? mem[rd_addr] : 32'd0;
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hdl/vtlc_mul.sv
// vtlc_mul: shared signed 33x33 multiplier with registered product
// depends on nothing beyond plain logic
`default_nettype none

module vtlc_mul
(
    input  wire logic               clk,
    input  wire logic signed [32:0] op_a,
    input  wire logic signed [32:0] op_b,
    output logic signed [65:0]      prod
);

    logic signed [65:0] prod_reg;

    // one product per cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> hdl/vtlc_sqdiv.sv
// vtlc_sqdiv: bit-serial square root (64 -> 32) and divide (64 / 32 -> 32)
// one shared subtract per cycle, 32 steps, done in the cycle after the last; depends on vtlc_pkg
`default_nettype none

module vtlc_sqdiv
    import vtlc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sd_ctrl_t    ctrl,
    input  wire logic [63:0] x,
    input  wire logic [31:0] den,
    output logic [31:0]      result,
    output logic             done
);

    logic        busy_reg, busy_next;
    logic        mode_reg, mode_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [33:0] rem_reg, rem_next;
    logic [63:0] sh_reg, sh_next;
    logic [31:0] q_reg, q_next;
    logic [35:0] lhs, rhs;
    logic [36:0] diff;
    logic        ge;

    // shared compare and subtract
    always_comb
    begin
        if (mode_reg == SD_SQRT)
        begin
            lhs = {rem_reg, sh_reg[63:62]};
            rhs = {2'b00, q_reg, 2'b01};
        end
        else
        begin
            lhs = {3'b000, rem_reg[31:0], sh_reg[63]};
            rhs = {4'b0000, den};
        end
        diff = {1'b0, lhs} - {1'b0, rhs};
        ge   = !diff[36];
    end

    // step control
    always_comb
    begin
        busy_next = busy_reg;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            mode_next = ctrl.mode;
            cnt_next  = '0;
            q_next    = '0;
            if (ctrl.mode == SD_SQRT)
            begin
                rem_next = '0;
                sh_next  = x;
            end
            else
            begin
                rem_next = {2'b00, x[63:32]};
                sh_next  = {x[31:0], 32'd0};
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[33:0] : lhs[33:0];
            q_next   = {q_reg[30:0], ge};
            sh_next  = (mode_reg == SD_SQRT) ? {sh_reg[61:0], 2'b00}
                                             : {sh_reg[62:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= SD_SQRT;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
    end

    assign result = q_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

>>> hdl/vector_transform_length_clamp_core.sv
// Frame transform with length clamp, signed fixed point (FRAC_BITS fraction bits).
// Steps of a scale-transform-clamp request: scale, transform, length, then sqrt and
//   divide only when clamping, output; range errors finish early. One request at a
//   time, the next can be taken once the result registers, later while a previous
//   result is stalled. Reset (async, low) clears the sequencer, out_valid and store
//   valid bits, so all three matrices read as zero.
`default_nettype none

module vector_transform_length_clamp_core
    import vtlc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         func,
    input  wire logic [1:0]         matrix_sel,
    input  wire logic [3:0]         elem_index,
    input  wire logic signed [31:0] elem_value,
    input  wire logic [1:0]         ref_x,
    input  wire logic [1:0]         ref_y,
    input  wire logic [1:0]         ref_z,
    input  wire logic signed [31:0] in_x,
    input  wire logic signed [31:0] in_y,
    input  wire logic signed [31:0] in_z,
    input  wire logic signed [31:0] gain,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic                    status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_XFORM = 3'd2;
    localparam logic [2:0] S_LEN   = 3'd3;
    localparam logic [2:0] S_SQRT  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

    logic [2:0]         state_reg, state_next;
    logic [1:0]         ph_reg, ph_next;
    logic [1:0]         k_reg, k_next;
    logic [1:0]         a_reg, a_next;
    logic [1:0]         func_reg, func_next;
    logic [1:0]         ref_reg [0:2];
    logic [1:0]         ref_next [0:2];
    logic signed [31:0] vec_reg [0:2];
    logic signed [31:0] vec_next [0:2];
    logic signed [31:0] res_reg [0:2];
    logic signed [31:0] res_next [0:2];
    logic signed [31:0] gain_reg, gain_next;
    logic signed [65:0] acc_reg, acc_next;
    logic [31:0]        len_reg, len_next;
    logic               err_reg, err_next;
    logic               ov_reg, ov_next;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic signed [31:0] ox_next, oy_next, oz_next;
    logic               ost_reg, ost_next;

    logic               accept;
    mem_wr_t            wr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [31:0]        rd_data;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    sd_ctrl_t           sd_ctrl;
    logic [63:0]        sd_x;
    logic [31:0]        sd_res;
    logic               sd_done;

    logic signed [65:0] rnd_src, rnd_full;
    logic               rnd_fits;
    logic [1:0]         cur_code;
    logic [31:0]        mag_k;
    logic [31:0]        q_lim;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // store, shared multiplier and sqrt / divide unit
    vtlc_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    vtlc_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    vtlc_sqdiv u_sqdiv
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (sd_ctrl),
        .x      (sd_x),
        .den    (len_reg),
        .result (sd_res),
        .done   (sd_done)
    );

    // store addressing for the current matrix element
    assign cur_code = ref_reg[a_reg];
    assign rd_addr  = frame_base(cur_code) + ADDR_W'({a_reg, 1'b0} + a_reg) + ADDR_W'(k_reg);

    // load write
    always_comb
    begin
        wr.en   = accept && (func == FN_LOAD) && (matrix_sel < SEL_LIMIT)
                  && (elem_index < IDX_LIMIT);
        wr.addr = frame_base(matrix_sel + 2'd1) + ADDR_W'(elem_index);
        wr.data = elem_value;
    end

    // magnitude of the current result component
    assign mag_k = res_reg[k_reg][31] ? (~res_reg[k_reg] + 32'd1) : res_reg[k_reg];

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SCALE:
            begin
                mul_a = 33'(vec_reg[k_reg]);
                mul_b = 33'(gain_reg);
            end
            S_XFORM:
            begin
                mul_a = (cur_code == FR_NONE) ? 33'sd0 : 33'(signed'(rd_data));
                mul_b = 33'(vec_reg[a_reg]);
            end
            S_LEN:
            begin
                if (k_reg == 2'd3)
                begin
                    mul_a = 33'(gain_reg);
                    mul_b = 33'(gain_reg);
                end
                else
                begin
                    mul_a = 33'(res_reg[k_reg]);
                    mul_b = 33'(res_reg[k_reg]);
                end
            end
            S_DIV:
            begin
                mul_a = signed'({1'b0, mag_k});
                mul_b = 33'(gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // round to nearest, ties up, and range check
    always_comb
    begin
        rnd_src  = (state_reg == S_SCALE) ? prod : acc_reg;
        rnd_full = (rnd_src + HALF) >>> FRAC_BITS;
        rnd_fits = (&rnd_full[65:31]) || !(|rnd_full[65:31]);
    end

    // clamp quotient to the gain
    assign q_lim = (sd_res > 32'(gain_reg)) ? 32'(gain_reg) : sd_res;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        k_next     = k_reg;
        a_next     = a_reg;
        func_next  = func_reg;
        gain_next  = gain_reg;
        acc_next   = acc_reg;
        len_next   = len_reg;
        err_next   = err_reg;
        ov_next    = ov_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oz_next    = oz_reg;
        ost_next   = ost_reg;
        sd_ctrl    = '{start: 1'b0, mode: SD_SQRT};
        sd_x       = acc_reg[63:0];
        for (int i = 0; i < 3; i++)
        begin
            ref_next[i] = ref_reg[i];
            vec_next[i] = vec_reg[i];
            res_next[i] = res_reg[i];
        end

        // result taken downstream
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next   = func;
                    ref_next[0] = ref_x;
                    ref_next[1] = ref_y;
                    ref_next[2] = ref_z;
                    vec_next[0] = in_x;
                    vec_next[1] = in_y;
                    vec_next[2] = in_z;
                    gain_next   = gain;
                    err_next    = 1'b0;
                    ph_next     = '0;
                    k_next      = '0;
                    a_next      = '0;
                    acc_next    = '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        res_next[i] = '0;
                    end
                    if (func == FN_XFORM)
                    begin
                        state_next = S_XFORM;
                    end
                    else if (func == FN_ACCEL)
                    begin
                        if (gain[31])
                        begin
                            err_next   = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_SCALE;
                        end
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_SCALE:
            begin
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else if (!rnd_fits)
                begin
                    err_next   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    vec_next[k_reg] = rnd_full[31:0];
                    ph_next         = 2'd0;
                    if (k_reg == 2'd2)
                    begin
                        k_next     = 2'd0;
                        state_next = S_XFORM;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            S_XFORM:
            begin
                case (ph_reg)
                    2'd0: ph_next = 2'd1;
                    2'd1: ph_next = 2'd2;
                    2'd2:
                    begin
                        acc_next = acc_reg + prod;
                        if (a_reg == 2'd2)
                        begin
                            ph_next = 2'd3;
                        end
                        else
                        begin
                            a_next  = a_reg + 2'd1;
                            ph_next = 2'd0;
                        end
                    end
                    default:
                    begin
                        if (!rnd_fits)
                        begin
                            err_next   = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            res_next[k_reg] = rnd_full[31:0];
                            acc_next        = '0;
                            a_next          = '0;
                            ph_next         = 2'd0;
                            if (k_reg == 2'd2)
                            begin
                                k_next     = 2'd0;
                                state_next = (func_reg == FN_ACCEL) ? S_LEN : S_OUT;
                            end
                            else
                            begin
                                k_next = k_reg + 2'd1;
                            end
                        end
                    end
                endcase
            end
            S_LEN:
            begin
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else if (k_reg != 2'd3)
                begin
                    acc_next = acc_reg + prod;
                    k_next   = k_reg + 2'd1;
                    ph_next  = 2'd0;
                end
                else if (acc_reg > prod)
                begin
                    sd_ctrl    = '{start: 1'b1, mode: SD_SQRT};
                    sd_x       = acc_reg[63:0];
                    state_next = S_SQRT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SQRT:
            begin
                if (sd_done)
                begin
                    len_next   = sd_res;
                    k_next     = 2'd0;
                    ph_next    = 2'd0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                case (ph_reg)
                    2'd0: ph_next = 2'd1;
                    2'd1:
                    begin
                        sd_ctrl = '{start: 1'b1, mode: SD_DIV};
                        sd_x    = prod[63:0] + {33'd0, len_reg[31:1]};
                        ph_next = 2'd2;
                    end
                    default:
                    begin
                        if (sd_done)
                        begin
                            res_next[k_reg] = res_reg[k_reg][31] ? -signed'(q_lim)
                                                                 : signed'(q_lim);
                            ph_next = 2'd0;
                            if (k_reg == 2'd2)
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                k_next = k_reg + 2'd1;
                            end
                        end
                    end
                endcase
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    ox_next    = err_reg ? 32'sd0 : res_reg[0];
                    oy_next    = err_reg ? 32'sd0 : res_reg[1];
                    oz_next    = err_reg ? 32'sd0 : res_reg[2];
                    ost_next   = err_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= '0;
            k_reg     <= '0;
            a_reg     <= '0;
            ov_reg    <= 1'b0;
            err_reg   <= 1'b0;
            func_reg  <= FN_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            k_reg     <= k_next;
            a_reg     <= a_next;
            ov_reg    <= ov_next;
            err_reg   <= err_next;
            func_reg  <= func_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            ref_reg[i] <= ref_next[i];
            vec_reg[i] <= vec_next[i];
            res_reg[i] <= res_next[i];
        end
        gain_reg <= gain_next;
        acc_reg  <= acc_next;
        len_reg  <= len_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oz_reg   <= oz_next;
        ost_reg  <= ost_next;
    end

    assign out_valid = ov_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;
    assign status    = ost_reg;

    // a pending result is never overwritten
    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && ov_reg && out_stall) |=> (state_reg == S_OUT))
        else $error("pending result overwritten");

    // an error result carries a zero vector
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ost_reg) |-> (ox_reg == 32'sd0 && oy_reg == 32'sd0 && oz_reg == 32'sd0))
        else $error("error result with nonzero vector");

    // the sqrt / divide unit finishes only while the sequencer waits for it
    a_sd_done: assert property (@(posedge clk) disable iff (!rst_n)
        sd_done |-> (state_reg == S_SQRT || state_reg == S_DIV))
        else $error("unexpected sqrt/divide completion");

endmodule

`default_nettype wire
